// ----- rtl/kgtr_pkg.sv -----
// shared types and constants of the key group threshold router
package kgtr_pkg;

   // field widths of records and of the running group sum
   localparam int KEY_W = 32;
   localparam int AMT_W = 32;
   localparam int SUM_W = 40;
   localparam int REC_W = KEY_W + AMT_W;

   // commands from the controller to the datapath
   typedef struct packed {
      logic latch;        // capture the accepted record
      logic add_input;    // add the record on the input port to the group
      logic add_hold;     // add the captured record to the group
      logic rd_en;        // read the buffer entry at the drain index
      logic idx_inc;      // step the drain index
      logic out_load;     // load the output register from the buffer read data
      logic group_clear;  // close the group after its last item
   } kgtr_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic flush_needed; // open group and the input key differs
      logic in_eos;       // end of stream on the input port
      logic hold_eos;     // end of stream on the captured record
      logic last_item;    // drain index points at the last buffered entry
      logic out_free;     // output register can take a new item
   } kgtr_status_type;

endpackage

// ----- rtl/kgtr_ram.sv -----
// generic single write port ram with registered read
module kgtr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/kgtr_ctrl.sv -----
// controller state machine: accepts records and sequences group drains
module kgtr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  kgtr_pkg::kgtr_status_type status,
   output kgtr_pkg::kgtr_cmd_type    cmd
);
   import kgtr_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;
   localparam logic [1:0] ST_ADD  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       add_after_ff, add_after_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      add_after_in = add_after_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               if (status.flush_needed) begin
                  // drain the old group, then add the captured record
                  add_after_in = 1'b1;
                  state_in     = ST_READ;
               end else begin
                  cmd.add_input = 1'b1;
                  if (status.in_eos) begin
                     add_after_in = 1'b0;
                     state_in     = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.last_item) begin
                  cmd.group_clear = 1'b1;
                  state_in        = add_after_ff ? ST_ADD : ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_ADD: begin
            cmd.add_hold = 1'b1;
            if (status.hold_eos) begin
               add_after_in = 1'b0;
               state_in     = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         add_after_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         add_after_ff <= add_after_in;
      end
   end

endmodule

// ----- rtl/kgtr_datapath.sv -----
// datapath: group buffer, running sum, limit register and output register
module kgtr_datapath #(
   parameter int GROUP_DEPTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  kgtr_pkg::kgtr_cmd_type    cmd,
   output kgtr_pkg::kgtr_status_type status,
   input  logic [63:0]               req_tdata,
   input  logic                      req_tlast,
   input  logic                      csr_we,
   input  logic [31:0]               csr_wdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [63:0]               rsp_tdata,
   output logic                      rsp_tlast,
   output logic [1:0]                rsp_tuser
);
   import kgtr_pkg::*;

   localparam int CNT_W = $clog2(GROUP_DEPTH + 1);
   localparam int IDX_W = $clog2(GROUP_DEPTH);

   // configuration
   logic signed [31:0]      limit_ff;
   // captured record
   logic [KEY_W-1:0]        hold_key_ff;
   logic [AMT_W-1:0]        hold_amt_ff;
   logic                    hold_eos_ff;
   // group state
   logic [KEY_W-1:0]        cur_key_ff, cur_key_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    open_ff, open_in;
   logic                    ovf_ff, ovf_in;
   logic [IDX_W-1:0]        idx_ff;
   // output register
   logic                    rsp_valid_ff;
   logic [REC_W-1:0]        rsp_data_ff;
   logic                    rsp_last_ff;
   logic                    rsp_whole_ff;
   logic                    rsp_ovf_ff;

   logic                    add;
   logic [KEY_W-1:0]        src_key;
   logic signed [AMT_W-1:0] src_amt;
   logic signed [SUM_W-1:0] base_sum;
   logic [CNT_W-1:0]        base_count;
   logic signed [SUM_W:0]   sum_wide;
   logic                    room;
   logic                    ram_we;
   logic [REC_W-1:0]        ram_rdata;
   logic                    wholesale;

   // status to the controller
   assign status.flush_needed = open_ff && (req_tdata[KEY_W-1:0] != cur_key_ff);
   assign status.in_eos       = req_tlast;
   assign status.hold_eos     = hold_eos_ff;
   assign status.last_item    = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign status.out_free     = !rsp_valid_ff || rsp_tready;

   // configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // capture of the accepted record
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         hold_key_ff <= req_tdata[KEY_W-1:0];
         hold_amt_ff <= req_tdata[REC_W-1:KEY_W];
         hold_eos_ff <= req_tlast;
      end
   end

   // record source and group accumulation with saturation
   assign add        = cmd.add_input | cmd.add_hold;
   assign src_key    = cmd.add_hold ? hold_key_ff : req_tdata[KEY_W-1:0];
   assign src_amt    = cmd.add_hold ? hold_amt_ff : req_tdata[REC_W-1:KEY_W];
   assign base_sum   = open_ff ? sum_ff : '0;
   assign base_count = open_ff ? count_ff : '0;
   assign sum_wide   = (SUM_W+1)'(base_sum) + (SUM_W+1)'(src_amt);
   assign room       = base_count < CNT_W'(GROUP_DEPTH);
   assign ram_we     = add && room;

   always_comb begin
      cur_key_in = cur_key_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      open_in    = open_ff;
      ovf_in     = ovf_ff;
      if (cmd.group_clear) begin
         sum_in   = '0;
         count_in = '0;
         open_in  = 1'b0;
         ovf_in   = 1'b0;
      end else if (add) begin
         open_in = 1'b1;
         if (!open_ff) begin
            cur_key_in = src_key;
         end
         // clamp to the signed sum range
         if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
         end else begin
            sum_in = sum_wide[SUM_W-1:0];
         end
         if (room) begin
            count_in = base_count + CNT_W'(1);
            ovf_in   = open_ff ? ovf_ff : 1'b0;
         end else begin
            count_in = base_count;
            ovf_in   = 1'b1;
         end
      end
   end

   // group state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         open_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         open_ff  <= open_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_key_ff <= cur_key_in;
   end

   // drain index
   always_ff @(posedge clock) begin
      if (reset || cmd.group_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   // group buffer
   kgtr_ram #(
      .WIDTH(REC_W),
      .DEPTH(GROUP_DEPTH)
   ) u_buffer (
      .clock(clock),
      .we   (ram_we),
      .waddr(base_count[IDX_W-1:0]),
      .wdata({src_amt, src_key}),
      .re   (cmd.rd_en),
      .raddr(idx_ff),
      .rdata(ram_rdata)
   );

   // route decision for the group being drained
   assign wholesale = (sum_ff >= SUM_W'(limit_ff));

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff  <= ram_rdata;
         rsp_last_ff  <= status.last_item;
         rsp_whole_ff <= wholesale;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_whole_ff};

endmodule

// ----- rtl/key_group_threshold_router.sv -----
// top level of the key group threshold router
// Records (key, signed amount) are taken in order and consecutive records with the
// same key are buffered as a group of up to GROUP_DEPTH entries while their amounts
// are summed with saturation to 40 bits; records past the buffer depth still count in
// the sum but are dropped and the group is flagged. A record with a new key, or one
// marked with tlast, drains the group in arrival order, each item tagged wholesale
// when the sum is at or above the limit register and marked tlast on the group's last
// item. A record that neither closes nor ends a group leaves input open. A drain reads
// each buffered record from the buffer ram, then loads the output register when it is
// free, and stops input while it runs; after a key change the new record is then added.
module key_group_threshold_router #(
   parameter int GROUP_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // record transfer
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // record_key [31:0], record_amount [63:32]
   input  logic        req_tlast,  // end_of_stream
   // limit register write
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,  // route_limit
   // result transfer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // out_key [31:0], out_amount [63:32]
   output logic        rsp_tlast,  // run_last
   output logic [1:0]  rsp_tuser   // to_wholesale [0], group_overflowed [1]
);
   import kgtr_pkg::*;

   kgtr_cmd_type    cmd;
   kgtr_status_type status;

   // controller
   kgtr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   kgtr_datapath #(
      .GROUP_DEPTH(GROUP_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ----- tb/tb_key_group_threshold_router.sv -----
// self-checking testbench of the key group threshold router
module tb_key_group_threshold_router;
   import kgtr_pkg::*;

   localparam int GROUP_DEPTH = 32;
   localparam logic signed [KEY_W-1:0] KMAX = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_W-1:0] KMIN = 32'sh8000_0000;
   localparam logic signed [SUM_W-1:0] SUM_HI = 40'sh7F_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_LO = 40'sh80_0000_0000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic signed [AMT_W-1:0] amount;
      logic                    eos;
   } rec_item_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic signed [AMT_W-1:0] amount;
      logic                    wholesale;
      logic                    run_last;
      logic                    overflowed;
   } result_type;

   // one stimulus row: n_typed < 0 means the predictor supplies the results
   typedef struct {
      rec_item_type rec;
      int           n_typed;
      result_type   exp0;
      result_type   exp1;
   } dir_row_type;

   localparam result_type NO_RES = '0;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // record_key [31:0], record_amount [63:32]
   logic        req_tlast;   // end_of_stream
   logic        csr_we;
   logic [31:0] csr_wdata;   // route_limit
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // out_key [31:0], out_amount [63:32]
   logic        rsp_tlast;   // run_last
   logic [1:0]  rsp_tuser;   // to_wholesale [0], group_overflowed [1]

   // predictor state
   logic signed [31:0]      limit_reg;
   logic signed [SUM_W-1:0] grp_sum;
   logic [KEY_W-1:0]        grp_key;
   bit                      grp_open;
   bit                      grp_ovf;
   rec_item_type            held_records[$];
   result_type              step_results[$];
   result_type              pending_results[$];
   logic [KEY_W-1:0]        key_pool[6];
   bit                      req_gaps_on;
   int                      error_count = 0;

   // directed rows, limit at its reset value of zero
   dir_row_type dir_table[17] = '{
      '{'{32'sd5, 32'sd10, 1'b1}, 1, '{32'sd5, 32'sd10, 1'b1, 1'b1, 1'b0}, NO_RES},
      '{'{KMAX, KMIN, 1'b1}, 1, '{KMAX, KMIN, 1'b0, 1'b1, 1'b0}, NO_RES},
      '{'{KMIN, KMAX, 1'b1}, 1, '{KMIN, KMAX, 1'b1, 1'b1, 1'b0}, NO_RES},
      '{'{32'sd0, 32'sd0, 1'b0}, 0, NO_RES, NO_RES},
      '{'{32'sd0, -32'sd1, 1'b0}, 0, NO_RES, NO_RES},
      '{'{32'sd7, 32'sd3, 1'b0}, 2, '{32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0},
        '{32'sd0, -32'sd1, 1'b0, 1'b1, 1'b0}},
      '{'{32'sd9, -32'sd3, 1'b1}, 2, '{32'sd7, 32'sd3, 1'b1, 1'b1, 1'b0},
        '{32'sd9, -32'sd3, 1'b0, 1'b1, 1'b0}},
      '{'{32'sd1, 32'sd5, 1'b0}, 0, NO_RES, NO_RES},
      '{'{32'sd1, -32'sd5, 1'b1}, 2, '{32'sd1, 32'sd5, 1'b1, 1'b0, 1'b0},
        '{32'sd1, -32'sd5, 1'b1, 1'b1, 1'b0}},
      '{'{-32'sd1, 32'sh5555_5555, 1'b0}, -1, NO_RES, NO_RES},
      '{'{-32'sd1, 32'shAAAA_AAAA, 1'b0}, -1, NO_RES, NO_RES},
      '{'{32'sh0F0F_0F0F, KMAX, 1'b0}, -1, NO_RES, NO_RES},
      '{'{32'sh0F0F_0F0F, KMAX, 1'b0}, -1, NO_RES, NO_RES},
      '{'{32'sh0F0F_0F0F, -32'sd1, 1'b1}, -1, NO_RES, NO_RES},
      '{'{KMAX, 32'sd0, 1'b0}, -1, NO_RES, NO_RES},
      '{'{KMIN, 32'sd0, 1'b0}, -1, NO_RES, NO_RES},
      '{'{KMIN, -32'sd7, 1'b1}, -1, NO_RES, NO_RES}
   };

   key_group_threshold_router #(
      .GROUP_DEPTH(GROUP_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hard limit on the run
   initial begin
      #10_000_000;
      $display("tb_key_group_threshold_router failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // mostly short gaps, now and then a long one
   function automatic int stall_length();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // emit the buffered group in arrival order
   function automatic void drain_group();
      logic wholesale;
      result_type res;
      wholesale = (grp_sum >= limit_reg);
      foreach (held_records[i]) begin
         res.key        = held_records[i].key;
         res.amount     = held_records[i].amount;
         res.wholesale  = wholesale;
         res.run_last   = (i == held_records.size() - 1);
         res.overflowed = grp_ovf;
         step_results.push_back(res);
      end
      held_records.delete();
      grp_sum  = '0;
      grp_open = 1'b0;
      grp_ovf  = 1'b0;
   endfunction

   // group one record and collect what it releases
   function automatic void route_record(input rec_item_type r);
      logic signed [SUM_W:0] wide;
      if (grp_open && r.key != grp_key)
         drain_group();
      if (!grp_open) begin
         grp_open = 1'b1;
         grp_key  = r.key;
         grp_sum  = '0;
         grp_ovf  = 1'b0;
         held_records.delete();
      end
      // saturating 40 bit group sum
      wide = grp_sum + $signed(r.amount);
      if (wide > SUM_HI)
         grp_sum = SUM_HI;
      else if (wide < SUM_LO)
         grp_sum = SUM_LO;
      else
         grp_sum = wide[SUM_W-1:0];
      if (held_records.size() < GROUP_DEPTH)
         held_records.push_back(r);
      else
         grp_ovf = 1'b1;
      if (r.eos)
         drain_group();
   endfunction

   // drive one record transfer; called and returns at a falling edge
   task automatic send_record(input dir_row_type row);
      int gap;
      gap = req_gaps_on ? stall_length() : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {row.rec.amount, row.rec.key};
      req_tlast  = row.rec.eos;
      do @(posedge clock); while (!req_tready);
      step_results.delete();
      route_record(row.rec);
      if (row.n_typed < 0) begin
         foreach (step_results[i]) pending_results.push_back(step_results[i]);
      end else begin
         if (row.n_typed > 0) pending_results.push_back(row.exp0);
         if (row.n_typed > 1) pending_results.push_back(row.exp1);
      end
      @(negedge clock);
   endtask

   // stop sending and let every pending result drain
   task automatic wait_quiet();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      limit_reg = value;
   endtask

   // runs of shared keys with random content, some past the buffer depth
   task automatic send_random_phase(input int n_items);
      dir_row_type row;
      int sent;
      int run_len;
      int r;
      logic [KEY_W-1:0] key;
      sent        = 0;
      row.n_typed = -1;
      row.exp0    = NO_RES;
      row.exp1    = NO_RES;
      key_pool[0] = '0;
      key_pool[1] = KMAX;
      key_pool[2] = KMIN;
      for (int k = 3; k < 6; k++) key_pool[k] = $urandom;
      while (sent < n_items) begin
         key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(5)] : $urandom;
         r = $urandom_range(99);
         if (r < 65)
            run_len = $urandom_range(4, 1);
         else if (r < 90)
            run_len = $urandom_range(12, 5);
         else
            run_len = $urandom_range(GROUP_DEPTH + 8, GROUP_DEPTH - 2);
         for (int i = 0; i < run_len && sent < n_items; i++) begin
            row.rec.key = key;
            case ($urandom_range(9))
               0:       row.rec.amount = KMAX;
               1:       row.rec.amount = KMIN;
               2, 3:    row.rec.amount = $urandom_range(200) - 100;
               default: row.rec.amount = $urandom;
            endcase
            // stray end of stream breaks a run now and then
            row.rec.eos = ($urandom_range(99) < 4);
            send_record(row);
            sent++;
         end
      end
      // close the last group so the block ends idle
      row.rec.key    = $urandom;
      row.rec.amount = $urandom;
      row.rec.eos    = 1'b1;
      send_record(row);
      wait_quiet();
   endtask

   // result receiver with random stalls and long stall-free stretches
   initial begin
      int burst;
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         burst = ($urandom_range(9) == 0) ? $urandom_range(200, 50) : $urandom_range(8, 1);
         rsp_tready = 1'b1;
         repeat (burst) @(negedge clock);
         gap = stall_length();
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin : check_rsp
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.key        = rsp_tdata[31:0];
         got.amount     = rsp_tdata[63:32];
         got.wholesale  = rsp_tuser[0];
         got.overflowed = rsp_tuser[1];
         got.run_last   = rsp_tlast;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result key %h amount %h",
                                      got.key, got.amount));
         end else begin
            want = pending_results.pop_front();
            if (got.key !== want.key)
               report_mismatch($sformatf("key got %h want %h", got.key, want.key));
            if (got.amount !== want.amount)
               report_mismatch($sformatf("amount got %h want %h (key %h)",
                                         got.amount, want.amount, want.key));
            if (got.wholesale !== want.wholesale)
               report_mismatch($sformatf("route got %b want %b (key %h)",
                                         got.wholesale, want.wholesale, want.key));
            if (got.run_last !== want.run_last)
               report_mismatch($sformatf("last got %b want %b (key %h)",
                                         got.run_last, want.run_last, want.key));
            if (got.overflowed !== want.overflowed)
               report_mismatch($sformatf("overflow got %b want %b (key %h)",
                                         got.overflowed, want.overflowed, want.key));
         end
      end
   end

   // reset, then the directed table and the random phases
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      limit_reg   = '0;
      grp_sum     = '0;
      grp_key     = '0;
      grp_open    = 1'b0;
      grp_ovf     = 1'b0;
      req_gaps_on = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows against the reset limit
      foreach (dir_table[i]) send_record(dir_table[i]);
      wait_quiet();

      // limit extremes, then a small window with a stall-free sender
      write_limit(KMIN);
      send_random_phase(120);
      write_limit(KMAX);
      send_random_phase(110);
      write_limit($urandom_range(2000) - 1000);
      req_gaps_on = 1'b0;
      send_random_phase(110);
      req_gaps_on = 1'b1;

      write_limit($urandom);
      send_random_phase(110);

      repeat (40) @(negedge clock);
      if (error_count == 0)
         $display("tb_key_group_threshold_router passed");
      else
         $display("tb_key_group_threshold_router failed");
      $finish;
   end

endmodule
